FILE: rtl/bgp_pkg.sv
package bgp_pkg;

  localparam int DIM_MAX = 1024;
  localparam int DIM_W   = 11;
  localparam int COORD_W = 10;
  localparam int WGT_W   = 21;
  localparam int CH_W    = 6;
  localparam int SUM_W   = WGT_W + CH_W;
  localparam int Q_W     = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W   = 2;
  localparam int CNT_W   = 3;
  localparam int ADDR_W  = 5;

  typedef enum logic [2:0] {
    REG_BL = 3'd0,
    REG_BR = 3'd1,
    REG_TL = 3'd2,
    REG_TR = 3'd3,
    REG_W  = 3'd4,
    REG_H  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CH_R = 2'd0,
    CH_G = 2'd1,
    CH_B = 2'd2
  } chan_t;

  typedef struct packed {
    logic [WGT_W-1:0] wbl;
    logic [WGT_W-1:0] wbr;
    logic [WGT_W-1:0] wtl;
    logic [WGT_W-1:0] wtr;
    logic [WGT_W-1:0] area;
  } wgt_item_t;

  typedef struct packed {
    logic [15:0] bl;
    logic [15:0] br;
    logic [15:0] tl;
    logic [15:0] tr;
  } corners_t;

  function automatic logic [CH_W-1:0] chan_of(logic [15:0] color, chan_t c);
    logic [CH_W-1:0] v;
    case (c)
      CH_R:    v = {1'b0, color[15:11]};
      CH_G:    v = color[10:5];
      CH_B:    v = {1'b0, color[4:0]};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/bilinear_gradient_pixel.sv
// Four-corner bilinear RGB565 gradient: one (x, y) item in, one color item out.
// Throughput is one item per clock while out_ready does not stall the output.
// From acceptance to out_valid an item passes through register stages, the
// first loaded at acceptance: 2 weight stages, the queue, 1 channel-sum stage
// and 6 restoring-divide stages, one quotient bit each, dividing by width*height.
// A 4-entry queue sits between the weight front end and the divide pipeline.
// Write corners and dimensions over APB only while no item is in flight;
// dimensions of 0 act as 1, above 1024 act as 1024, coordinates clamp.
module bilinear_gradient_pixel
  import bgp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_pixel_x,
  input  logic [COORD_W-1:0] in_pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_pixel_color,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  corners_t         corners_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic             wr_en;
  reg_idx_t         idx;
  logic             f_valid, f_ready, q_valid, q_ready;
  wgt_item_t        f_item, q_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corners_r <= '0;
      width_r   <= DIM_W'(1);
      height_r  <= DIM_W'(1);
    end else if (wr_en) begin
      case (idx)
        REG_BL:  corners_r.bl <= pwdata[15:0];
        REG_BR:  corners_r.br <= pwdata[15:0];
        REG_TL:  corners_r.tl <= pwdata[15:0];
        REG_TR:  corners_r.tr <= pwdata[15:0];
        REG_W:   width_r      <= pwdata[DIM_W-1:0];
        REG_H:   height_r     <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BL:  prdata = {16'd0, corners_r.bl};
      REG_BR:  prdata = {16'd0, corners_r.br};
      REG_TL:  prdata = {16'd0, corners_r.tl};
      REG_TR:  prdata = {16'd0, corners_r.tr};
      REG_W:   prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_H:   prdata = {{(32-DIM_W){1'b0}}, height_r};
      default: prdata = '0;
    endcase
  end

  bgp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .image_width  (width_r),
    .image_height (height_r),
    .item_valid   (f_valid),
    .item_ready   (f_ready),
    .item         (f_item)
  );

  bgp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  bgp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (q_valid),
    .item_ready      (q_ready),
    .item            (q_item),
    .corners         (corners_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color)
  );

endmodule

FILE: rtl/bgp_front.sv
module bgp_front
  import bgp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_pixel_x,
  input  logic [COORD_W-1:0] in_pixel_y,
  input  logic [DIM_W-1:0]   image_width,
  input  logic [DIM_W-1:0]   image_height,
  output logic               item_valid,
  input  logic               item_ready,
  output wgt_item_t          item
);

  logic               v0_r, v1_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [DIM_W-1:0]   w_r, h_r;
  logic [COORD_W-1:0] x_nxt, y_nxt;
  logic [DIM_W-1:0]   w_nxt, h_nxt, wm1, hm1;
  logic [DIM_W-1:0]   wx, hy;
  logic [2*DIM_W-1:0] p_bl, p_br, p_tl, p_tr, p_area;
  wgt_item_t          item_r, item_nxt;
  logic               en;

  assign en       = !v1_r || item_ready;
  assign in_ready = en;

  always_comb begin
    w_nxt = image_width;
    if (image_width == '0) w_nxt = DIM_W'(1);
    else if (image_width > DIM_W'(DIM_MAX)) w_nxt = DIM_W'(DIM_MAX);
    h_nxt = image_height;
    if (image_height == '0) h_nxt = DIM_W'(1);
    else if (image_height > DIM_W'(DIM_MAX)) h_nxt = DIM_W'(DIM_MAX);
    wm1 = w_nxt - DIM_W'(1);
    hm1 = h_nxt - DIM_W'(1);
    x_nxt = in_pixel_x;
    if ({1'b0, in_pixel_x} > wm1) x_nxt = wm1[COORD_W-1:0];
    y_nxt = in_pixel_y;
    if ({1'b0, in_pixel_y} > hm1) y_nxt = hm1[COORD_W-1:0];
  end

  always_comb begin
    wx     = w_r - {1'b0, x_r};
    hy     = h_r - {1'b0, y_r};
    p_bl   = hy * wx;
    p_br   = hy * {1'b0, x_r};
    p_tl   = {1'b0, y_r} * wx;
    p_tr   = {1'b0, y_r} * {1'b0, x_r};
    p_area = w_r * h_r;
    item_nxt.wbl  = p_bl[WGT_W-1:0];
    item_nxt.wbr  = p_br[WGT_W-1:0];
    item_nxt.wtl  = p_tl[WGT_W-1:0];
    item_nxt.wtr  = p_tr[WGT_W-1:0];
    item_nxt.area = p_area[WGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      item_r <= item_nxt;
    end
  end

  assign item_valid = v1_r;
  assign item       = item_r;

endmodule

FILE: rtl/bgp_fifo.sv
module bgp_fifo
  import bgp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  wgt_item_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output wgt_item_t rd_data
);

  wgt_item_t        mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign wr_ready = cnt_r != CNT_W'(FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PTR_W'(1);
      if (pop) rp_r <= rp_r + PTR_W'(1);
      if (push && !pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

FILE: rtl/bgp_back.sv
module bgp_back
  import bgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  wgt_item_t   item,
  input  corners_t    corners,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_color
);

  localparam int NST = Q_W + 1;

  logic             vld_r  [NST];
  logic [WGT_W-1:0] area_r [NST];
  logic [SUM_W-1:0] rem_r  [NST][3];
  logic [Q_W-1:0]   q_r    [NST][3];
  logic [SUM_W-1:0] rem_nxt [NST][3];
  logic [Q_W-1:0]   q_nxt   [NST][3];
  logic [SUM_W-1:0] sh;
  logic             en;

  assign en         = !vld_r[NST-1] || out_ready;
  assign item_ready = en;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem_nxt[0][c] = SUM_W'(chan_of(corners.bl, chan_t'(c))) * SUM_W'(item.wbl)
                    + SUM_W'(chan_of(corners.br, chan_t'(c))) * SUM_W'(item.wbr)
                    + SUM_W'(chan_of(corners.tl, chan_t'(c))) * SUM_W'(item.wtl)
                    + SUM_W'(chan_of(corners.tr, chan_t'(c))) * SUM_W'(item.wtr);
      q_nxt[0][c] = '0;
    end
    sh = '0;
    // restoring division, one quotient bit per stage, MSB first
    for (int s = 0; s < Q_W; s++) begin
      for (int c = 0; c < 3; c++) begin
        sh = {{(SUM_W-WGT_W){1'b0}}, area_r[s]} << (Q_W - 1 - s);
        rem_nxt[s+1][c] = rem_r[s][c];
        q_nxt[s+1][c]   = q_r[s][c];
        if (rem_r[s][c] >= sh) begin
          rem_nxt[s+1][c]           = rem_r[s][c] - sh;
          q_nxt[s+1][c][Q_W-1-s]    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= item_valid;
      for (int s = 1; s < NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area_r[0] <= item.area;
      for (int s = 1; s < NST; s++) area_r[s] <= area_r[s-1];
      for (int s = 0; s < NST; s++) begin
        for (int c = 0; c < 3; c++) begin
          rem_r[s][c] <= rem_nxt[s][c];
          q_r[s][c]   <= q_nxt[s][c];
        end
      end
    end
  end

  assign out_valid       = vld_r[NST-1];
  assign out_pixel_color = {q_r[NST-1][CH_R][4:0], q_r[NST-1][CH_G],
                            q_r[NST-1][CH_B][4:0]};

endmodule
